// ----- src/bitmap_frame_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Shared property forms for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Sizes, codes, state encoding and shared types of the frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

   // Bitmap geometry
   localparam int NUM_FRAMES  = 32768;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = NUM_FRAMES / WORD_BITS;
   localparam int WORD_AW     = $clog2(MAP_WORDS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int BITCNT_W    = BIT_W + 1;
   localparam int FRAME_W     = $clog2(NUM_FRAMES);
   localparam int LIM_W       = FRAME_W + 1;
   localparam int CNT_W       = 16;
   localparam int FRAME_SHIFT = 12;
   localparam int FRAME_BYTES = 4096;

   // Transaction field widths
   localparam int KIND_W    = 2;
   localparam int ADDR_W    = 27;
   localparam int LEN_W     = 28;
   localparam int STATUS_W  = 2;
   localparam int MEMKB_W   = 18;

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic REG_MEMORY_KB = 1'b0;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [FRAME_W-1:0]   frame_type;
   typedef logic [LIM_W-1:0]     lim_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC     = 2'd0,
      KIND_FREE      = 2'd1,
      KIND_MARK_FREE = 2'd2,
      KIND_MARK_USED = 2'd3
   } kind_type;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SEARCH,
      ST_WRITE,
      ST_RESP
   } fsm_state_type;

   // Outcome of scanning one bitmap word
   typedef struct packed {
      logic      hit;
      frame_type start;
      lim_type   run_out;
   } scan_result_type;

endpackage

// ----- src/bfa_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Valid/ready request and response channels of the frame allocator.
// ----------------------------------------------------------------------------
interface bfa_req_if;
   import bfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ADDR_W-1:0]   address;
   logic [LEN_W-1:0]    length;

   modport source (output valid, kind, address, length, input ready);
   modport sink   (input valid, kind, address, length, output ready);
endinterface

interface bfa_rsp_if;
   import bfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   alloc_address;
   logic [CNT_W-1:0]    free_frames;
   logic [CNT_W-1:0]    used_frames;

   modport source (output valid, status, alloc_address, free_frames, used_frames,
                   input ready);
   modport sink   (input valid, status, alloc_address, free_frames, used_frames,
                   output ready);
endinterface

// ----- src/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- src/bfa_scan.sv -----
// ----------------------------------------------------------------------------
// Bitmap word scanner
// Looks for the first run of free frames of the needed length that ends in
// one bitmap word, given the free run carried in from the words below.
// ----------------------------------------------------------------------------
module bfa_scan (
   input  bfa_pkg::word_type        word_data,
   input  bfa_pkg::lim_type         base,
   input  bfa_pkg::lim_type         lim,
   input  bfa_pkg::lim_type         run_in,
   input  bfa_pkg::cnt_type         need,
   output bfa_pkg::scan_result_type result
);
   import bfa_pkg::*;

   lim_type             span;
   word_type            lim_mask;
   word_type            free_bits;
   word_type            ero [BIT_W];
   word_type            fit;
   logic [BITCNT_W-1:0] trail_free;
   logic [BITCNT_W-1:0] lead_free;
   logic [BIT_W-1:0]    low_idx;
   logic                carry_fit;
   logic                inner_fit;
   logic                small_need;

   // frames at or above the limit count as used
   assign span = lim - base;

   always_comb begin
      lim_mask = '0;
      if (lim > base) begin
         if (span >= LIM_W'(WORD_BITS)) begin
            lim_mask = '1;
         end else begin
            lim_mask = (word_type'(1) << span[BIT_W-1:0]) - word_type'(1);
         end
      end
   end

   assign free_bits = ~word_data & lim_mask;

   // free frames at the bottom and at the top of the word
   always_comb begin
      trail_free = BITCNT_W'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!free_bits[i]) trail_free = BITCNT_W'(i);
      end
   end

   always_comb begin
      lead_free = BITCNT_W'(WORD_BITS);
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!free_bits[i]) lead_free = BITCNT_W'(WORD_BITS - 1 - i);
      end
   end

   // ero[k] marks bits that end a free run of at least 2**k frames
   always_comb begin
      ero[0] = free_bits;
      for (int k = 1; k < BIT_W; k++) begin
         ero[k] = ero[k-1] & (ero[k-1] << (1 << (k - 1)));
      end
   end

   // compose runs from the binary digits of the needed length
   always_comb begin
      logic started;
      started = 1'b0;
      fit     = '0;
      for (int k = 0; k < BIT_W; k++) begin
         if (need[k]) begin
            fit     = started ? (ero[k] & (fit << (1 << k))) : ero[k];
            started = 1'b1;
         end
      end
   end

   always_comb begin
      low_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (fit[i]) low_idx = BIT_W'(i);
      end
   end

   // a run that continues from below always ends lowest
   assign small_need = (need[CNT_W-1:BIT_W] == '0);
   assign carry_fit  = ((LIM_W+1)'(run_in) + (LIM_W+1)'(trail_free)) >= (LIM_W+1)'(need);
   assign inner_fit  = small_need && (|fit);

   assign result.hit     = carry_fit || inner_fit;
   assign result.start   = carry_fit ? FRAME_W'(base - run_in)
                         : FRAME_W'(base + LIM_W'(low_idx) + LIM_W'(1) - LIM_W'(need));
   assign result.run_out = (free_bits == '1) ? run_in + LIM_W'(WORD_BITS)
                         : LIM_W'(lead_free);

endmodule

// ----- src/bitmap_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit allocator of 4 KiB frames over a used/free bitmap in RAM.
// ----------------------------------------------------------------------------
// The bitmap (one bit per frame, 1 = used) lives in a 1024 x 32 RAM and is
// walked one word per cycle. After reset a clearing pass writes every word to
// all used, during which no transaction is accepted (memory_kb writes are
// taken). One request is worked at a time. Allocate scans the bitmap words
// from the bottom up to the word where the run ends (up to 1024), then
// rewrites each word the run spans; a request refused for zero length or for
// too few free frames goes to the response without a search. Free and the
// region kinds rewrite each word the run spans. The RAM's single read port
// and registered read data set the one word per cycle rate. A new request is
// taken while the previous response waits.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bitmap_frame_allocator (
   input  logic                         clock,
   input  logic                         reset,
   bfa_req_if.sink                      req_ch,
   bfa_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bfa_pkg::PADDR_W-1:0]  paddr,
   input  logic [bfa_pkg::PDATA_W-1:0]  pwdata,
   output logic [bfa_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);
   import bfa_pkg::*;

   // control and state registers
   fsm_state_type          state_ff, state_in;
   logic [WORD_AW-1:0]     clr_ff, clr_in;
   logic [MEMKB_W-1:0]     memkb_ff, memkb_in;
   cnt_type                count_ff, count_in;
   logic                   dv_ff, dv_in;
   logic [WORD_AW-1:0]     issue_ff, issue_in;
   logic [WORD_AW-1:0]     proc_ff, proc_in;
   lim_type                srun_ff, srun_in;

   // request held for the duration of the work
   kind_type               kind_ff, kind_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [LEN_W-1:0]       len_ff, len_in;

   // run writer
   frame_type              first_ff, first_in;
   frame_type              last_ff, last_in;
   logic                   used_ff, used_in;

   // result and response registers
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [ADDR_W-1:0]      res_addr_ff, res_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   cnt_type                rsp_free_ff, rsp_free_in;
   cnt_type                rsp_used_ff, rsp_used_in;

   // RAM port
   logic                   ram_we, ram_re;
   logic [WORD_AW-1:0]     ram_waddr, ram_raddr;
   word_type               ram_wdata, ram_rdata;

   // derived values
   lim_type                lim;
   logic                   accept;
   logic                   csr_write;
   frame_type              s_frame;
   lim_type                s_ext;
   logic [LEN_W:0]         len_round;
   logic [LEN_W-1:0]       n_raw;
   lim_type                room;
   lim_type                n_clip;
   lim_type                run_end;
   frame_type              run_last;
   logic                   run_skip;
   logic [LIM_W:0]         sum_up;
   cnt_type                cnt_up, cnt_dn;
   logic                   len_zero, len_big;
   cnt_type                need;
   lim_type                base;
   logic                   last_word;
   scan_result_type        scan;
   logic                   scan_hit, scan_miss;
   frame_type              alloc_last;
   logic [LIM_W:0]         hit_end;
   logic [BIT_W-1:0]       lo_bit, hi_bit;
   word_type               wr_mask;
   logic                   write_done;
   logic                   rsp_free_slot;
   logic                   csr_sel_ok;

   // ---------------------------------------------------------------- config
   assign pready     = 1'b1;
   assign csr_write  = psel && penable && pwrite && pready;
   assign csr_sel_ok = (paddr[PADDR_W-1] == REG_MEMORY_KB);
   assign prdata     = csr_sel_ok ? PDATA_W'(memkb_ff) : '0;
   assign memkb_in   = (csr_write && csr_sel_ok) ? pwdata[MEMKB_W-1:0] : memkb_ff;

   // frame limit, capped at the bitmap size
   assign lim = (LIM_W'(memkb_ff >> 2) > LIM_W'(NUM_FRAMES)) ? LIM_W'(NUM_FRAMES)
              : LIM_W'(memkb_ff >> 2);

   assign accept = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------- run setup
   assign s_frame   = addr_ff[ADDR_W-1:FRAME_SHIFT];
   assign s_ext     = LIM_W'(s_frame);
   assign len_round = (LEN_W+1)'(len_ff) + (LEN_W+1)'(FRAME_BYTES - 1);
   assign n_raw     = (kind_ff == KIND_FREE) ? len_ff
                    : LEN_W'(len_round[LEN_W:FRAME_SHIFT]);
   assign room      = lim - s_ext;
   assign run_skip  = (s_ext >= lim) || (n_raw == '0);
   assign n_clip    = (n_raw > LEN_W'(room)) ? room : LIM_W'(n_raw);
   assign run_end   = s_ext + n_clip;
   assign run_last  = FRAME_W'(run_end - LIM_W'(1));

   // free count after freeing or marking used, saturating
   assign sum_up = (LIM_W+1)'(count_ff) + (LIM_W+1)'(n_clip);
   assign cnt_up = (LIM_W'(count_ff) >= lim) ? count_ff
                 : ((sum_up > (LIM_W+1)'(lim)) ? CNT_W'(lim) : CNT_W'(sum_up));
   assign cnt_dn = (LIM_W'(count_ff) > n_clip) ? count_ff - CNT_W'(n_clip) : '0;

   assign len_zero = (len_ff == '0);
   assign len_big  = (len_ff > LEN_W'(count_ff));
   assign need     = len_ff[CNT_W-1:0];

   // ---------------------------------------------------------------- search
   assign base      = LIM_W'({proc_ff, BIT_W'(0)});
   assign last_word = ((LIM_W+1)'(base) + (LIM_W+1)'(WORD_BITS)) >= (LIM_W+1)'(lim);

   bfa_scan u_scan (
      .word_data (ram_rdata),
      .base      (base),
      .lim       (lim),
      .run_in    (srun_ff),
      .need      (need),
      .result    (scan)
   );

   assign scan_hit   = (state_ff == ST_SEARCH) && dv_ff && scan.hit;
   assign scan_miss  = (state_ff == ST_SEARCH) && dv_ff && !scan.hit && last_word;
   assign alloc_last = FRAME_W'(LIM_W'(scan.start) + LIM_W'(need) - LIM_W'(1));
   assign hit_end    = (LIM_W+1)'(scan.start) + (LIM_W+1)'(need);

   // ---------------------------------------------------------------- run write
   assign lo_bit  = (proc_ff == first_ff[FRAME_W-1:BIT_W]) ? first_ff[BIT_W-1:0] : '0;
   assign hi_bit  = (proc_ff == last_ff[FRAME_W-1:BIT_W]) ? last_ff[BIT_W-1:0] : '1;
   assign wr_mask = ({WORD_BITS{1'b1}} << lo_bit)
                  & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
   assign write_done = (state_ff == ST_WRITE) && dv_ff
                     && (proc_ff == last_ff[FRAME_W-1:BIT_W]);

   assign rsp_free_slot = !rsp_valid_ff || rsp_ch.ready;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == WORD_AW'(MAP_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (kind_ff == KIND_ALLOC) begin
               state_in = (len_zero || len_big) ? ST_RESP : ST_SEARCH;
            end else begin
               state_in = run_skip ? ST_RESP : ST_WRITE;
            end
         end
         ST_SEARCH: begin
            if (scan_hit) begin
               state_in = ST_WRITE;
            end else if (scan_miss) begin
               state_in = ST_RESP;
            end
         end
         ST_WRITE: begin
            if (write_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free_slot) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ch.ready = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = proc_ff;
      ram_wdata    = used_ff ? (ram_rdata | wr_mask) : (ram_rdata & ~wr_mask);
      ram_re       = 1'b0;
      ram_raddr    = issue_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '1;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_SEARCH: begin
            ram_re = 1'b1;
         end
         ST_WRITE: begin
            ram_re = 1'b1;
            ram_we = dv_ff;
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.alloc_address = rsp_addr_ff;
   assign rsp_ch.free_frames   = rsp_free_ff;
   assign rsp_ch.used_frames   = rsp_used_ff;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      clr_in        = clr_ff;
      count_in      = count_ff;
      dv_in         = dv_ff;
      issue_in      = issue_ff;
      proc_in       = proc_ff;
      srun_in       = srun_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_used_in   = rsp_used_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + WORD_AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = kind_type'(req_ch.kind);
               addr_in = req_ch.address;
               len_in  = req_ch.length;
            end
         end
         ST_SETUP: begin
            status_in   = STATUS_OK;
            res_addr_in = '0;
            dv_in       = 1'b0;
            srun_in     = '0;
            if (kind_ff == KIND_ALLOC) begin
               issue_in = '0;
               if (len_zero) begin
                  status_in = STATUS_ZERO_LEN;
               end else if (len_big) begin
                  status_in = STATUS_NO_FIT;
               end
            end else begin
               issue_in = s_frame[FRAME_W-1:BIT_W];
               first_in = s_frame;
               last_in  = run_last;
               used_in  = (kind_ff == KIND_MARK_USED);
               if (!run_skip) begin
                  count_in = (kind_ff == KIND_MARK_USED) ? cnt_dn : cnt_up;
               end
            end
         end
         ST_SEARCH: begin
            issue_in = issue_ff + WORD_AW'(1);
            proc_in  = issue_ff;
            dv_in    = 1'b1;
            if (dv_ff) srun_in = scan.run_out;
            if (scan_hit) begin
               first_in    = scan.start;
               last_in     = alloc_last;
               used_in     = 1'b1;
               count_in    = count_ff - need;
               res_addr_in = {scan.start, FRAME_SHIFT'(0)};
               issue_in    = scan.start[FRAME_W-1:BIT_W];
               dv_in       = 1'b0;
            end else if (scan_miss) begin
               status_in = STATUS_NO_FIT;
            end
         end
         ST_WRITE: begin
            issue_in = issue_ff + WORD_AW'(1);
            proc_in  = issue_ff;
            dv_in    = 1'b1;
         end
         ST_RESP: begin
            if (rsp_free_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_free_in   = count_ff;
               rsp_used_in   = (lim > LIM_W'(count_ff)) ? CNT_W'(lim - LIM_W'(count_ff)) : '0;
            end
         end
         default: begin
            dv_in = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         memkb_ff     <= '0;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         memkb_ff     <= memkb_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      proc_ff       <= proc_in;
      srun_ff       <= srun_in;
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      used_ff       <= used_in;
      status_ff     <= status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // ---------------------------------------------------------------- bitmap RAM
   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- checks
   `BFA_ASSERT_SAME(a_no_rw_collide, clock, reset, ram_we && ram_re, ram_waddr != ram_raddr, "bitmap word read while written")
   `BFA_ASSERT_SAME(a_hit_in_limit, clock, reset, scan_hit, hit_end <= (LIM_W+1)'(lim), "allocated run crosses frame limit")
   `BFA_ASSERT_NEXT(a_alloc_count, clock, reset, scan_hit, count_ff <= $past(count_ff), "free count grew on allocate")
   `BFA_ASSERT_SAME(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_RESP, "response raised outside response state")

endmodule

// ----- tb/sv/bitmap_frame_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Sends allocate, free and region transactions with random gaps and response
// stalls. A bit-level copy of the frame bitmap and free count predicts each
// response, and every response is compared field by field.
// ----------------------------------------------------------------------------
import bfa_pkg::*;

typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   alloc_address;
   cnt_type             free_frames;
   cnt_type             used_frames;
} answer_type;

// Frame bitmap predictor plus the queue of responses still owed
class frame_book;
   word_type           map_words [MAP_WORDS];
   int unsigned        free_count;
   logic [MEMKB_W-1:0] memory_kb;
   answer_type         expected_answers [$];
   int                 mismatches;

   function new();
      foreach (map_words[i]) map_words[i] = '1;
      free_count = 0;
      memory_kb  = '0;
      mismatches = 0;
   endfunction

   function int unsigned frame_limit();
      int unsigned lim;
      lim = memory_kb >> 2;
      if (lim > NUM_FRAMES) lim = NUM_FRAMES;
      return lim;
   endfunction

   function void set_frame(longint unsigned f, bit used);
      map_words[f / WORD_BITS][f % WORD_BITS] = used;
   endfunction

   // Frames at or past the limit are untouched; count moves per frame touched
   function void write_frames(longint unsigned start, longint unsigned n, bit used);
      int unsigned     lim;
      longint unsigned f;
      lim = frame_limit();
      if (start >= lim) return;
      if (n > lim - start) n = lim - start;
      for (f = start; f < start + n; f++) begin
         set_frame(f, used);
         if (used) begin
            if (free_count > 0) free_count--;
         end else if (free_count < lim && free_count < 16'hffff) begin
            free_count++;
         end
      end
   endfunction

   // Lowest start of n contiguous free frames below the limit, -1 if none
   function longint find_first_fit(longint unsigned n);
      int unsigned     lim;
      int unsigned     f;
      longint unsigned run;
      lim = frame_limit();
      f   = 0;
      run = 0;
      while (f < lim) begin
         if (f % WORD_BITS == 0 && map_words[f / WORD_BITS] == '1) begin
            run = 0;
            f += WORD_BITS;
         end else begin
            if (map_words[f / WORD_BITS][f % WORD_BITS]) begin
               run = 0;
            end else begin
               run++;
               if (run == n) return longint'(f) - longint'(n - 1);
            end
            f++;
         end
      end
      return -1;
   endfunction

   // Accepted request: update the bitmap copy and queue the response
   function void note_request(kind_type kind, logic [ADDR_W-1:0] address,
                              logic [LEN_W-1:0] length);
      answer_type      ans;
      longint          hit;
      longint unsigned i;
      int unsigned     lim;
      ans = '0;
      case (kind)
         KIND_ALLOC: begin
            if (length == 0) begin
               ans.status = STATUS_ZERO_LEN;
            end else if (length > free_count) begin
               ans.status = STATUS_NO_FIT;
            end else begin
               hit = find_first_fit(length);
               if (hit < 0) begin
                  ans.status = STATUS_NO_FIT;
               end else begin
                  for (i = 0; i < length; i++) set_frame(hit + i, 1'b1);
                  free_count -= length;
                  ans.alloc_address = ADDR_W'(hit << FRAME_SHIFT);
               end
            end
         end
         KIND_FREE: write_frames(address >> FRAME_SHIFT, length, 1'b0);
         default: begin
            // region size in bytes, rounded up to whole frames
            write_frames(address >> FRAME_SHIFT,
                         (longint'(length) + FRAME_BYTES - 1) >> FRAME_SHIFT,
                         kind == KIND_MARK_USED);
         end
      endcase
      lim = frame_limit();
      ans.free_frames = CNT_W'(free_count);
      ans.used_frames = (lim > free_count) ? CNT_W'(lim - free_count) : '0;
      expected_answers.push_back(ans);
   endfunction

   function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_answer(answer_type got);
      answer_type want;
      if (expected_answers.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
         mismatches++;
         return;
      end
      want = expected_answers.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("alloc_address", want.alloc_address, got.alloc_address);
      compare_field("free_frames", want.free_frames, got.free_frames);
      compare_field("used_frames", want.used_frames, got.used_frames);
   endfunction
endclass

module bitmap_frame_allocator_tb;

   localparam int CYCLE_LIMIT    = 6_000_000;
   localparam int PRESSURE_AFTER = 120;
   localparam int PRESSURE_HOLD  = 400;
   localparam int DRAIN_CYCLES   = 2200;
   localparam logic [PADDR_W-1:0] MEMORY_KB_ADDR = PADDR_W'(4 * REG_MEMORY_KB);

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   int                 cycle_count = 0;
   bit                 no_idle = 1'b0;
   frame_book          book = new();

   logic [MEMKB_W-1:0] phase_kb [6] = '{18'd131072, 18'd150, 18'h3ffff,
                                         18'd4096, 18'd1, 18'd131072};
   int                 phase_items [6] = '{180, 60, 140, 100, 20, 80};

   bfa_req_if req_ch ();
   bfa_rsp_if rsp_ch ();

   bitmap_frame_allocator uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("status: fail");
         $finish;
      end
   end

   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request transaction; valid stays high when the next one follows at once
   task automatic send_request(kind_type kind, logic [ADDR_W-1:0] address,
                               logic [LEN_W-1:0] length);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.address <= address;
      req_ch.length  <= length;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      book.note_request(kind, address, length);
   endtask

   // Random request, biased toward the low frames so searches stay short
   task automatic send_random(int unsigned lim);
      int unsigned       pick;
      int unsigned       frame;
      int unsigned       span;
      kind_type          kind;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? KIND_ALLOC : (pick < 60) ? KIND_FREE :
             (pick < 85) ? KIND_MARK_FREE : KIND_MARK_USED;
      span = (lim == 0) ? NUM_FRAMES : (lim < 2048) ? lim : 2048;
      frame = ($urandom_range(0, 99) < 70) ? $urandom_range(0, span - 1)
                                            : $urandom_range(0, NUM_FRAMES - 1);
      address = {frame[FRAME_W-1:0], 12'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 5) length = LEN_W'($urandom);
      else if (pick < 10) length = '0;
      else if (kind == KIND_ALLOC) length = (pick < 22) ? $urandom_range(1, 512)
                                                        : $urandom_range(1, 16);
      else if (kind == KIND_FREE) length = $urandom_range(1, 48);
      else length = $urandom_range(1, 48 * FRAME_BYTES);
      send_request(kind, address, length);
   endtask

   // Stop sending and wait until every response is back
   task automatic drain_answers();
      req_ch.valid <= 1'b0;
      while (book.expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, then read back
   task automatic csr_write(logic [MEMKB_W-1:0] kb);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MEMORY_KB_ADDR;
      pwdata  <= PDATA_W'(kb);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      book.memory_kb = kb;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      book.compare_field("memory_kb readback", kb, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Response side: check, then pick the next ready level
   initial begin
      answer_type  got;
      int unsigned stall_left;
      int unsigned answers_seen;
      bit          pressure_done;
      rsp_ch.ready  = 1'b0;
      stall_left    = 0;
      answers_seen  = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.status        = rsp_ch.status;
            got.alloc_address = rsp_ch.alloc_address;
            got.free_frames   = rsp_ch.free_frames;
            got.used_frames   = rsp_ch.used_frames;
            book.check_answer(got);
            answers_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!pressure_done && answers_seen >= PRESSURE_AFTER) begin
            // long hold-off so the block backs up and stalls requests
            pressure_done = 1'b1;
            stall_left    = PRESSURE_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < 15) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Stimulus
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_ALLOC;
      req_ch.address = '0;
      req_ch.length  = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // limit still zero: everything ignored, nothing to allocate
      send_request(KIND_MARK_FREE, 27'd0, 28'd8192);
      send_request(KIND_ALLOC, 27'd0, 28'd1);
      send_request(KIND_FREE, 27'd0, 28'd4);
      drain_answers();
      csr_write(18'd131072);

      // zero lengths, capacity refusals, clipping at the top frame
      send_request(KIND_ALLOC, 27'd0, 28'd0);
      send_request(KIND_ALLOC, 27'd0, 28'd1);
      send_request(KIND_MARK_FREE, 27'd0, 28'd0);
      send_request(KIND_MARK_FREE, 27'h123, 28'd262143);
      send_request(KIND_ALLOC, 27'd0, 28'd10);
      send_request(KIND_ALLOC, 27'd0, 28'd100);
      send_request(KIND_FREE, 27'h7ffffff, 28'hfffffff);
      // mark used on a frame already used still counts down
      send_request(KIND_MARK_USED, 27'd0, 28'd1);
      send_request(KIND_ALLOC, 27'd0, 28'd30);
      send_request(KIND_ALLOC, 27'd0, 28'd24);
      // whole map used, then whole map free; count saturates both ways
      send_request(KIND_MARK_USED, 27'd0, 28'hfffffff);
      send_request(KIND_MARK_FREE, 27'd0, 28'h8000000);
      send_request(KIND_FREE, 27'd0, 28'd5);
      send_request(KIND_ALLOC, 27'd0, 28'd32768);
      send_request(KIND_ALLOC, 27'd0, 28'hfffffff);
      // enough free frames but no contiguous run
      send_request(KIND_FREE, 27'd0, 28'd4);
      send_request(KIND_MARK_FREE, 27'(10 * FRAME_BYTES), 28'(4 * FRAME_BYTES));
      send_request(KIND_ALLOC, 27'd0, 28'd5);
      send_request(KIND_ALLOC, 27'd0, 28'd4);
      // run across a word boundary
      send_request(KIND_FREE, 27'(30 * FRAME_BYTES + 5), 28'd6);
      send_request(KIND_ALLOC, 27'd0, 28'd6);
      send_request(KIND_FREE, 27'h3fff000, 28'd0);
      send_request(KIND_MARK_USED, 27'(10 * FRAME_BYTES), 28'(4 * FRAME_BYTES + 1));

      // random phases at several limits
      for (int p = 0; p < 6; p++) begin
         drain_answers();
         csr_write(phase_kb[p]);
         no_idle = (p == 2);
         repeat (phase_items[p]) send_random(book.frame_limit());
      end
      no_idle = 1'b0;

      drain_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.expected_answers.size() != 0)
         $display("%0t: %0d responses missing", $time, book.expected_answers.size());
      if (book.mismatches == 0 && book.expected_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
